FILE: rtl/button_debounce_click_classifier_assert.svh
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_ASSERT_SVH

// same-cycle implication, gated by reset
`define BDCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, gated by reset
`define BDCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bdcc_pkg.sv
package bdcc_pkg;

   localparam int BUTTON_COUNT            = 3;
   localparam int TICK_COUNT_BITS_DEFAULT = 16;
   localparam int CFG_BITS                = 16;
   localparam int CSR_INDEX_BITS          = 2;

   localparam int BTN_LEFT  = 0;
   localparam int BTN_RIGHT = 1;
   localparam int BTN_TALK  = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DOUBLE_CLICK_TICKS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PRESSED_LEVEL      = 2'd2;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET     = 16'd20;
   localparam logic [CFG_BITS-1:0] DOUBLE_CLICK_RESET = 16'd300;
   localparam logic                PRESSED_RESET      = 1'b0;

   typedef struct packed {
      logic                pressed_level;
      logic [CFG_BITS-1:0] debounce_ticks;
   } lane_cfg_type;

   typedef struct packed {
      logic single_click;
      logic double_click;
   } gesture_type;

   typedef struct packed {
      logic [BUTTON_COUNT-1:0] press;
      gesture_type             gesture;
   } result_type;

endpackage

FILE: rtl/bdcc_req_if.sv
interface bdcc_req_if;
   logic valid;
   logic ready;
   logic left_raw;
   logic right_raw;
   logic talk_raw;
   logic gestures_suppressed;

   modport source (output valid, output left_raw, output right_raw, output talk_raw,
                   output gestures_suppressed, input ready);
   modport sink   (input valid, input left_raw, input right_raw, input talk_raw,
                   input gestures_suppressed, output ready);
endinterface

FILE: rtl/bdcc_rsp_if.sv
interface bdcc_rsp_if;
   logic valid;
   logic ready;
   logic left_press;
   logic right_press;
   logic talk_press;
   logic single_click;
   logic double_click;

   modport source (output valid, output left_press, output right_press, output talk_press,
                   output single_click, output double_click, input ready);
   modport sink   (input valid, input left_press, input right_press, input talk_press,
                   input single_click, input double_click, output ready);
endinterface

FILE: rtl/bdcc_csr_if.sv
interface bdcc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bdcc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [bdcc_pkg::CFG_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bdcc_lane.sv
module bdcc_lane #(
   parameter int TICK_COUNT_BITS = bdcc_pkg::TICK_COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   raw,
   input  bdcc_pkg::lane_cfg_type cfg,
   output logic                   press
);

   localparam int CMP_BITS = (TICK_COUNT_BITS > bdcc_pkg::CFG_BITS) ?
                             TICK_COUNT_BITS : bdcc_pkg::CFG_BITS;

   logic                       raw_pressed;
   logic                       last_ff, last_in;
   logic                       stable_ff, stable_in;
   logic [TICK_COUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      raw_pressed = (raw == cfg.pressed_level);
      last_in     = raw_pressed;
      if (raw_pressed != last_ff) begin
         count_in = '0;
      end else if (&count_ff) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + 1'b1;
      end
      stable_in = stable_ff;
      press     = 1'b0;
      if ((CMP_BITS'(count_in) >= CMP_BITS'(cfg.debounce_ticks)) &&
          (raw_pressed != stable_ff)) begin
         stable_in = raw_pressed;
         press     = raw_pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= 1'b0;
         stable_ff <= 1'b0;
         count_ff  <= '0;
      end else if (accept) begin
         last_ff   <= last_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/bdcc_merge.sv
module bdcc_merge #(
   parameter int TICK_COUNT_BITS = bdcc_pkg::TICK_COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          talk_press,
   input  logic                          suppress,
   input  logic [bdcc_pkg::CFG_BITS-1:0] window_ticks,
   output bdcc_pkg::gesture_type         gesture
);

   localparam int CMP_BITS = (TICK_COUNT_BITS > bdcc_pkg::CFG_BITS) ?
                             TICK_COUNT_BITS : bdcc_pkg::CFG_BITS;

   logic                       pending_ff, pending_in;
   logic [TICK_COUNT_BITS-1:0] since_ff, since_in, since_inc;

   always_comb begin
      since_inc  = (&since_ff) ? since_ff : since_ff + 1'b1;
      since_in   = since_inc;
      pending_in = pending_ff;
      gesture    = '0;
      if (suppress) begin
         pending_in = 1'b0;
      end else begin
         if (talk_press) begin
            if (pending_ff && (CMP_BITS'(since_inc) <= CMP_BITS'(window_ticks))) begin
               pending_in           = 1'b0;
               gesture.double_click = 1'b1;
            end else begin
               pending_in = 1'b1;
               since_in   = '0;
            end
         end
         if (pending_in && (CMP_BITS'(since_in) > CMP_BITS'(window_ticks))) begin
            pending_in           = 1'b0;
            gesture.single_click = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         since_ff   <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         since_ff   <= since_in;
      end
   end

endmodule

FILE: rtl/button_debounce_click_classifier.sv
// channel  | port   | dir | transaction
// ---------+--------+-----+-----------------------------------------------
// request  | req_ch | in  | one tick: three raw levels, gesture suppress
// response | rsp_ch | out | press pulses, single and double click
// csr      | csr_ch | in  | register write, index and data
//
// One tick per clock unless stalled; rsp valid the cycle after accept.
// All button lanes and the click merge finish within the accepting cycle.
// The response register lets a new request in while the old one is taken.
// A stalled response holds and blocks only the next request.
// Synchronous reset restores register defaults and releases every button.
module button_debounce_click_classifier #(
   parameter int TICK_COUNT_BITS = bdcc_pkg::TICK_COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bdcc_req_if.sink    req_ch,
   bdcc_rsp_if.source  rsp_ch,
   bdcc_csr_if.sink    csr_ch
);

   logic                              accept;
   logic [bdcc_pkg::BUTTON_COUNT-1:0] raw_vec;
   logic [bdcc_pkg::BUTTON_COUNT-1:0] press_vec;
   bdcc_pkg::lane_cfg_type            lane_cfg;
   bdcc_pkg::gesture_type             gesture;

   logic [bdcc_pkg::CFG_BITS-1:0]     debounce_ff, debounce_in;
   logic [bdcc_pkg::CFG_BITS-1:0]     window_ff, window_in;
   logic                              level_ff, level_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   bdcc_pkg::result_type              result_ff, result_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      debounce_in = debounce_ff;
      window_in   = window_ff;
      level_in    = level_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            bdcc_pkg::REG_DEBOUNCE_TICKS:     debounce_in = csr_ch.data;
            bdcc_pkg::REG_DOUBLE_CLICK_TICKS: window_in   = csr_ch.data;
            bdcc_pkg::REG_PRESSED_LEVEL:      level_in    = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= bdcc_pkg::DEBOUNCE_RESET;
         window_ff   <= bdcc_pkg::DOUBLE_CLICK_RESET;
         level_ff    <= bdcc_pkg::PRESSED_RESET;
      end else begin
         debounce_ff <= debounce_in;
         window_ff   <= window_in;
         level_ff    <= level_in;
      end
   end

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign raw_vec[bdcc_pkg::BTN_LEFT]  = req_ch.left_raw;
   assign raw_vec[bdcc_pkg::BTN_RIGHT] = req_ch.right_raw;
   assign raw_vec[bdcc_pkg::BTN_TALK]  = req_ch.talk_raw;

   assign lane_cfg.pressed_level  = level_ff;
   assign lane_cfg.debounce_ticks = debounce_ff;

   for (genvar b = 0; b < bdcc_pkg::BUTTON_COUNT; b++) begin : g_lane
      bdcc_lane #(
         .TICK_COUNT_BITS (TICK_COUNT_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .accept (accept),
         .raw    (raw_vec[b]),
         .cfg    (lane_cfg),
         .press  (press_vec[b])
      );
   end

   bdcc_merge #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .talk_press   (press_vec[bdcc_pkg::BTN_TALK]),
      .suppress     (req_ch.gestures_suppressed),
      .window_ticks (window_ff),
      .gesture      (gesture)
   );

   always_comb begin
      result_in.press   = press_vec;
      result_in.gesture = gesture;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.left_press   = result_ff.press[bdcc_pkg::BTN_LEFT];
   assign rsp_ch.right_press  = result_ff.press[bdcc_pkg::BTN_RIGHT];
   assign rsp_ch.talk_press   = result_ff.press[bdcc_pkg::BTN_TALK];
   assign rsp_ch.single_click = result_ff.gesture.single_click;
   assign rsp_ch.double_click = result_ff.gesture.double_click;

endmodule

FILE: rtl/bdcc_checker.sv
`include "button_debounce_click_classifier_assert.svh"

module bdcc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_talk_press,
   input logic rsp_single_click,
   input logic rsp_double_click
);

   `BDCC_ASSERT_NOW(a_click_exclusive, clock, reset, rsp_valid, !(rsp_single_click && rsp_double_click), "single and double click in one transaction")
   `BDCC_ASSERT_NOW(a_double_needs_press, clock, reset, rsp_valid && rsp_double_click, rsp_talk_press, "double click without talk press")
   `BDCC_ASSERT_NEXT(a_rsp_follows_req, clock, reset, req_valid && req_ready, rsp_valid, "accepted request gave no response")
   `BDCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "stalled response dropped")

endmodule

bind button_debounce_click_classifier bdcc_checker u_bdcc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_talk_press   (rsp_ch.talk_press),
   .rsp_single_click (rsp_ch.single_click),
   .rsp_double_click (rsp_ch.double_click)
);
